// ===== sv/modbus_rtu_reply_receiver_macros.svh =====
// Assertion macros for the Modbus RTU reply receiver.
`ifndef MODBUS_RTU_REPLY_RECEIVER_MACROS_SVH
`define MODBUS_RTU_REPLY_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MRR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mrr_pkg.sv =====
// Types, constants and helper functions for the Modbus RTU reply receiver.
package mrr_pkg;

   localparam int MAX_FRAME_DEF = 256;
   localparam int LEN_W = 9;
   localparam int SIL_W = 17;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0] EXC_BIT = 8'h80;
   localparam logic [8:0] EXC_LEN = 9'd5;
   localparam logic [8:0] WRITE_LEN = 9'd8;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [SIL_W-1:0] SIL_MAX = '1;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   localparam logic [1:0] STAT_GOOD = 2'd0;
   localparam logic [1:0] STAT_EXC = 2'd1;
   localparam logic [1:0] STAT_TIMEOUT = 2'd2;

   localparam logic [7:0] FC_READ_FIRST = 8'd1;
   localparam logic [7:0] FC_READ_LAST = 8'd4;
   localparam logic [7:0] FC_READ_HOLDING = 8'd3;
   localparam logic [7:0] FC_WRITE_COIL = 8'd5;
   localparam logic [7:0] FC_WRITE_REG = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS = 8'd16;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic [10:0] request_count;
   } req_type;

   typedef struct packed {
      logic word_valid;
      logic [15:0] data_word;
      logic [4:0] bits_valid;
      logic done_res;
      logic [1:0] status;
   } rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic is_read(input logic [7:0] fc);
      return (fc >= FC_READ_FIRST) && (fc <= FC_READ_LAST);
   endfunction

   function automatic logic is_write(input logic [7:0] fc);
      return (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG) ||
             (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS);
   endfunction

endpackage

// ===== sv/mrr_step.sv =====
// Reply parser state and its per-word update: length, CRC, data words, timeout.
module mrr_step #(
   parameter int MAX_FRAME = mrr_pkg::MAX_FRAME_DEF
) (
   input logic clock,
   input logic reset,
   input logic enable,
   input mrr_pkg::req_type in_word,
   input logic [15:0] timeout_ticks,
   output mrr_pkg::rsp_type out_word
);
   import mrr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

   logic waiting_ff, waiting_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] fc_ff, fc_in;
   logic [7:0] dbc_ff, dbc_in;
   logic [LEN_W-1:0] elen_ff, elen_in;
   logic [7:0] held_ff, held_in;
   logic held_flag_ff, held_flag_in;
   logic [SIL_W-1:0] sil_ff, sil_in;
   logic [10:0] coils_ff, coils_in;
   logic [7:0] crc_lo_ff, crc_lo_in;

   logic [7:0] b;
   logic [CMP_W-1:0] p_x, el_x, dend_x;
   logic [SIL_W-1:0] sil_inc;
   logic [4:0] cap;
   logic [4:0] take;
   logic last;

   always_comb begin
      b = in_word.rx_byte;
      waiting_in = waiting_ff;
      seen_in = seen_ff;
      crc_in = crc_ff;
      fc_in = fc_ff;
      dbc_in = dbc_ff;
      elen_in = elen_ff;
      held_in = held_ff;
      held_flag_in = held_flag_ff;
      sil_in = sil_ff;
      coils_in = coils_ff;
      crc_lo_in = crc_lo_ff;
      out_word = '0;
      p_x = CMP_W'(seen_ff);
      el_x = '0;
      dend_x = '0;
      sil_inc = (sil_ff == SIL_MAX) ? sil_ff : sil_ff + 1'b1;
      cap = '0;
      take = '0;
      last = 1'b0;

      case (in_word.func)
         FUNC_START: begin
            waiting_in = 1'b1;
            seen_in = '0;
            crc_in = CRC_INIT;
            fc_in = '0;
            dbc_in = '0;
            elen_in = '0;
            held_in = '0;
            held_flag_in = 1'b0;
            sil_in = '0;
            coils_in = in_word.request_count;
            crc_lo_in = '0;
         end
         FUNC_TICK: begin
            if (waiting_ff) begin
               sil_in = sil_inc;
               if (sil_inc > SIL_W'(timeout_ticks)) begin
                  waiting_in = 1'b0;
                  out_word.done_res = 1'b1;
                  out_word.status = STAT_TIMEOUT;
               end
            end
         end
         FUNC_BYTE: begin
            if (waiting_ff && (seen_ff < CNT_W'(MAX_FRAME))) begin
               seen_in = seen_ff + 1'b1;
               sil_in = '0;
               if (p_x == CMP_W'(1)) begin
                  fc_in = b;
                  if ((b & EXC_BIT) != 8'h00) begin
                     elen_in = EXC_LEN;
                  end else if (is_write(b)) begin
                     elen_in = WRITE_LEN;
                  end else begin
                     elen_in = '0;
                  end
               end else if ((p_x == CMP_W'(2)) && is_read(fc_ff)) begin
                  dbc_in = b;
                  elen_in = EXC_LEN + LEN_W'(b);
               end
               el_x = CMP_W'(elen_in);
               dend_x = CMP_W'(3) + CMP_W'(dbc_in);
               last = (p_x + CMP_W'(1)) == dend_x;

               if ((el_x == '0) || ((p_x + CMP_W'(2)) < el_x)) begin
                  crc_in = crc_feed(crc_ff, b);
                  if (is_read(fc_in) && (p_x >= CMP_W'(3)) && (p_x < dend_x)) begin
                     if (fc_in >= FC_READ_HOLDING) begin
                        if (held_flag_ff) begin
                           out_word.word_valid = 1'b1;
                           out_word.data_word = {held_ff, b};
                           out_word.bits_valid = 5'd16;
                           held_flag_in = 1'b0;
                        end else begin
                           held_in = b;
                           held_flag_in = 1'b1;
                        end
                     end else begin
                        if (held_flag_ff) begin
                           out_word.word_valid = 1'b1;
                           out_word.data_word = {b, held_ff};
                           cap = 5'd16;
                           held_flag_in = 1'b0;
                        end else if (last) begin
                           out_word.word_valid = 1'b1;
                           out_word.data_word = {8'h00, b};
                           cap = 5'd8;
                        end else begin
                           held_in = b;
                           held_flag_in = 1'b1;
                        end
                        if (out_word.word_valid) begin
                           take = (coils_ff < 11'(cap)) ? coils_ff[4:0] : cap;
                           out_word.bits_valid = take;
                           coils_in = coils_ff - 11'(take);
                        end
                     end
                  end
               end else if ((p_x + CMP_W'(2)) == el_x) begin
                  crc_lo_in = b;
               end else if ((p_x + CMP_W'(1)) == el_x) begin
                  if ({b, crc_lo_ff} == crc_ff) begin
                     waiting_in = 1'b0;
                     out_word.done_res = 1'b1;
                     out_word.status = ((fc_ff & EXC_BIT) != 8'h00) ? STAT_EXC : STAT_GOOD;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         seen_ff <= '0;
         crc_ff <= CRC_INIT;
         fc_ff <= '0;
         dbc_ff <= '0;
         elen_ff <= '0;
         held_ff <= '0;
         held_flag_ff <= 1'b0;
         sil_ff <= '0;
         coils_ff <= '0;
         crc_lo_ff <= '0;
      end else if (enable) begin
         waiting_ff <= waiting_in;
         seen_ff <= seen_in;
         crc_ff <= crc_in;
         fc_ff <= fc_in;
         dbc_ff <= dbc_in;
         elen_ff <= elen_in;
         held_ff <= held_in;
         held_flag_ff <= held_flag_in;
         sil_ff <= sil_in;
         coils_ff <= coils_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

// ===== sv/modbus_rtu_reply_receiver.sv =====
// Top level of the Modbus RTU reply receiver: input register, parser, result register.
//
//   port group   dir   handshake         payload
//   req_         in    valid / ready     mrr_pkg::req_type
//   rsp_         out   valid / ready     mrr_pkg::rsp_type
//   csr_         in    write enable      timeout_ticks, 16 bits
//
// Every word gives one result word, which passes through the input register and then the result register.
// A new word is accepted every cycle while the result register is not stalled; the parser state updates once per word.
// A stalled result register holds the input register, which then drops req_ready.
// Synchronous reset clears the parser state and sets timeout_ticks to 1000.
`include "modbus_rtu_reply_receiver_macros.svh"

module modbus_rtu_reply_receiver #(
   parameter int MAX_FRAME = mrr_pkg::MAX_FRAME_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input mrr_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output mrr_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [15:0] csr_wdata
);
   import mrr_pkg::*;

   logic in_valid_ff, in_valid_in;
   req_type in_ff;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type step_out;
   logic [15:0] timeout_ff;
   logic advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   mrr_step #(
      .MAX_FRAME(MAX_FRAME)
   ) u_step (
      .clock(clock),
      .reset(reset),
      .enable(advance),
      .in_word(in_ff),
      .timeout_ticks(timeout_ff),
      .out_word(step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= step_out;
      end
   end

   `MRR_ASSERT_NOW(a_word_done, rsp_data.word_valid, !rsp_data.done_res, "word and done")
   `MRR_ASSERT_NOW(a_status_done, !rsp_data.done_res, rsp_data.status == STAT_GOOD, "stray status")
   `MRR_ASSERT_NEXT(a_in_held, in_valid_ff && !advance, in_valid_ff && $stable(in_ff), "lost word")

endmodule
